// ----- design/gcp_pkg.sv -----
`default_nettype none
package gcp_pkg;

  // field widths
  localparam int unsigned IN_W     = 16;
  localparam int unsigned COV_W    = 48;
  localparam int unsigned OPA_W    = 16;
  localparam int unsigned ROT_W    = 32;
  localparam int unsigned EXP_IN_W = 17;
  localparam int unsigned EXP_W    = 58;

  // pipeline depths
  localparam int unsigned TAYLOR_TERMS = 12;
  localparam int unsigned EXP_LAT      = 3 + 3 * TAYLOR_TERMS + 1;
  localparam int unsigned ROT_QW       = 31;
  localparam int unsigned ROT_LAT      = 3 + ROT_QW + 1;
  localparam int unsigned COV_LAT      = 6;
  localparam int unsigned OPA_QW       = 17;
  localparam int unsigned OPA_LAT      = EXP_LAT + OPA_QW + 2;
  localparam int unsigned PIPE_LAT     = OPA_LAT;

  // fixed-point constants
  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic signed [COV_W-1:0] COV_MAX = {1'b0, {(COV_W - 1){1'b1}}};
  localparam logic signed [COV_W-1:0] COV_MIN = {1'b1, {(COV_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [IN_W-1:0] log_scale_x;
    logic signed [IN_W-1:0] log_scale_y;
    logic signed [IN_W-1:0] log_scale_z;
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    logic signed [IN_W-1:0] opacity_logit;
  } gcp_in_t;

  typedef struct packed {
    logic signed [COV_W-1:0] cov_xx;
    logic signed [COV_W-1:0] cov_xy;
    logic signed [COV_W-1:0] cov_xz;
    logic signed [COV_W-1:0] cov_yy;
    logic signed [COV_W-1:0] cov_yz;
    logic signed [COV_W-1:0] cov_zz;
    logic [OPA_W-1:0]        opacity;
    logic                    bad_quat;
  } gcp_out_t;

endpackage
`default_nettype wire

// ----- design/gcp_dly.sv -----
`default_nettype none
module gcp_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  // plain shift line, moves with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule
`default_nettype wire

// ----- design/gcp_div.sv -----
`default_nettype none
module gcp_div #(
  parameter int unsigned NW = 63,
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 31
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  // one restoring step per stage, most significant quotient bit first
  for (genvar s = 0; s < QW; s++) begin : g_bit
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    if (s == 0) begin : g_src
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_src
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = !diff[DW];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= fits ? diff[DW-1:0] : trial[DW-1:0];
        low_q[s] <= low_in << 1;
        den_q[s] <= den_in;
        quo_q[s] <= {quo_in[QW-2:0], fits};
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule
`default_nettype wire

// ----- design/gcp_exp.sv -----
`default_nettype none
module gcp_exp (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [gcp_pkg::EXP_IN_W-1:0]  arg_i,
  output logic [gcp_pkg::EXP_W-1:0]            exp_o
);
  import gcp_pkg::*;

  localparam int unsigned NT = TAYLOR_TERMS;
  localparam logic [30:0] ONE_Q30 = 31'(64'd1 << 30);

  logic signed [48:0] y_full;
  logic signed [47:0] y_q;
  logic [59:0]        lp_q;
  logic signed [5:0]  n1_q;
  logic [59:0]        xr_sum;
  logic [29:0]        x0_q;
  logic signed [5:0]  n0_q;

  // base-2 exponent, then fraction times ln 2
  assign y_full = arg_i * LOG2E_Q30;
  assign xr_sum = lp_q + 60'(64'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q  <= y_full[47:0];
      lp_q <= y_q[41:12] * LN2_Q30;
      n1_q <= y_q[47:42];
      x0_q <= xr_sum[59:30];
      n0_q <= n1_q;
    end
  end

  logic [60:0]       a_prod_q [NT];
  logic [29:0]       a_x_q    [NT];
  logic [31:0]       a_f_q    [NT];
  logic signed [5:0] a_n_q    [NT];
  logic [30:0]       b_t_q    [NT];
  logic [30:0]       b_qe_q   [NT];
  logic [29:0]       b_x_q    [NT];
  logic [31:0]       b_f_q    [NT];
  logic signed [5:0] b_n_q    [NT];
  logic [30:0]       c_term_q [NT];
  logic [29:0]       c_x_q    [NT];
  logic [31:0]       c_f_q    [NT];
  logic signed [5:0] c_n_q    [NT];

  // taylor series: multiply, divide by k through a reciprocal, correct and add
  for (genvar s = 0; s < NT; s++) begin : g_term
    localparam int unsigned Kval  = s + 1;
    localparam logic [31:0] Recip = 32'(64'h8000_0000 / Kval);
    localparam logic [3:0]  Kc    = 4'(Kval);

    logic [30:0]       term_in;
    logic [29:0]       x_in;
    logic [31:0]       f_in;
    logic signed [5:0] n_in;
    logic [60:0]       rnd_sum;
    logic [62:0]       qe_full;
    logic [34:0]       qk;
    logic [30:0]       rem;
    logic [30:0]       term_d;

    if (s == 0) begin : g_src
      assign term_in = ONE_Q30;
      assign x_in    = x0_q;
      assign f_in    = 32'(ONE_Q30);
      assign n_in    = n0_q;
    end else begin : g_src
      assign term_in = c_term_q[s-1];
      assign x_in    = c_x_q[s-1];
      assign f_in    = c_f_q[s-1];
      assign n_in    = c_n_q[s-1];
    end

    assign rnd_sum = a_prod_q[s] + 61'(64'(Kval) << 29);
    assign qe_full = rnd_sum[60:30] * Recip;
    assign qk      = b_qe_q[s] * Kc;
    assign rem     = b_t_q[s] - qk[30:0];
    assign term_d  = b_qe_q[s] + 31'(rem >= 31'(Kval));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_prod_q[s] <= term_in * x_in;
        a_x_q[s]    <= x_in;
        a_f_q[s]    <= f_in;
        a_n_q[s]    <= n_in;
        b_t_q[s]    <= rnd_sum[60:30];
        b_qe_q[s]   <= qe_full[61:31];
        b_x_q[s]    <= a_x_q[s];
        b_f_q[s]    <= a_f_q[s];
        b_n_q[s]    <= a_n_q[s];
        c_term_q[s] <= term_d;
        c_x_q[s]    <= b_x_q[s];
        c_f_q[s]    <= b_f_q[s] + 32'(term_d);
        c_n_q[s]    <= b_n_q[s];
      end
    end
  end

  logic signed [6:0] sh;
  logic [4:0]        rs;
  logic [32:0]       f_rnd;
  logic [EXP_W-1:0]  exp_d;
  logic [EXP_W-1:0]  exp_q;

  // scale by 2^(n+2), rounding half up on a right shift
  always_comb begin
    sh    = 7'(c_n_q[NT-1]) + 7'sd2;
    rs    = 5'(-sh);
    f_rnd = 33'(c_f_q[NT-1]) + (33'd1 << (rs - 5'd1));
    if (!sh[6]) begin
      exp_d = EXP_W'(c_f_q[NT-1]) << sh[4:0];
    end else begin
      exp_d = EXP_W'(f_rnd >> rs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q <= exp_d;
    end
  end

  assign exp_o = exp_q;

endmodule
`default_nettype wire

// ----- design/gcp_rot.sv -----
`default_nettype none
module gcp_rot (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [gcp_pkg::IN_W-1:0]         quat_w_i,
  input  logic signed [gcp_pkg::IN_W-1:0]         quat_x_i,
  input  logic signed [gcp_pkg::IN_W-1:0]         quat_y_i,
  input  logic signed [gcp_pkg::IN_W-1:0]         quat_z_i,
  output logic [8:0][gcp_pkg::ROT_W-1:0]          rm_o,
  output logic                                    bad_o
);
  import gcp_pkg::*;

  logic signed [31:0] prd_q [10];
  logic signed [34:0] num_q [9];
  logic [32:0]        n2_q;
  logic [34:0]        mag [9];
  logic [62:0]        dnum_q [9];
  logic [32:0]        dden_q;
  logic [8:0]         neg_q;
  logic               bad_q;
  logic [8:0]         neg_dly;
  logic               bad_dly;
  logic [ROT_QW-1:0]  quo [9];
  logic [8:0][ROT_W-1:0] rm_q;
  logic               bad_out_q;

  // squares and cross products: ww xx yy zz xy wz xz wy yz wx
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prd_q[0] <= quat_w_i * quat_w_i;
      prd_q[1] <= quat_x_i * quat_x_i;
      prd_q[2] <= quat_y_i * quat_y_i;
      prd_q[3] <= quat_z_i * quat_z_i;
      prd_q[4] <= quat_x_i * quat_y_i;
      prd_q[5] <= quat_w_i * quat_z_i;
      prd_q[6] <= quat_x_i * quat_z_i;
      prd_q[7] <= quat_w_i * quat_y_i;
      prd_q[8] <= quat_y_i * quat_z_i;
      prd_q[9] <= quat_w_i * quat_x_i;
    end
  end

  // squared norm and the nine numerators, row-major
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n2_q <= 33'(prd_q[0][30:0]) + 33'(prd_q[1][30:0])
            + 33'(prd_q[2][30:0]) + 33'(prd_q[3][30:0]);
      num_q[0] <= 35'(prd_q[0]) + 35'(prd_q[1]) - 35'(prd_q[2]) - 35'(prd_q[3]);
      num_q[1] <= (35'(prd_q[4]) + 35'(prd_q[5])) <<< 1;
      num_q[2] <= (35'(prd_q[6]) - 35'(prd_q[7])) <<< 1;
      num_q[3] <= (35'(prd_q[4]) - 35'(prd_q[5])) <<< 1;
      num_q[4] <= 35'(prd_q[0]) - 35'(prd_q[1]) + 35'(prd_q[2]) - 35'(prd_q[3]);
      num_q[5] <= (35'(prd_q[8]) + 35'(prd_q[9])) <<< 1;
      num_q[6] <= (35'(prd_q[6]) + 35'(prd_q[7])) <<< 1;
      num_q[7] <= (35'(prd_q[8]) - 35'(prd_q[9])) <<< 1;
      num_q[8] <= 35'(prd_q[0]) - 35'(prd_q[1]) - 35'(prd_q[2]) + 35'(prd_q[3]);
    end
  end

  // magnitude, rounding offset and sign ahead of the dividers
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mag[i] = num_q[i][34] ? 35'(-num_q[i]) : 35'(num_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        dnum_q[i] <= {mag[i][32:0], 30'd0} + 63'(n2_q[32:1]);
        neg_q[i]  <= num_q[i][34];
      end
      dden_q <= n2_q;
      bad_q  <= (n2_q == '0);
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_div
    gcp_div #(
      .NW (63),
      .DW (33),
      .QW (ROT_QW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .num_i (dnum_q[i]),
      .den_i (dden_q),
      .quo_o (quo[i])
    );
  end

  gcp_dly #(
    .W (10),
    .N (ROT_QW)
  ) u_sign_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   ({bad_q, neg_q}),
    .q_o   ({bad_dly, neg_dly})
  );

  // put the sign back
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) begin
        rm_q[i] <= neg_dly[i] ? (32'd0 - 32'(quo[i])) : 32'(quo[i]);
      end
      bad_out_q <= bad_dly;
    end
  end

  assign rm_o  = rm_q;
  assign bad_o = bad_out_q;

endmodule
`default_nettype wire

// ----- design/gcp_cov.sv -----
`default_nettype none
module gcp_cov (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [8:0][gcp_pkg::ROT_W-1:0]      rm_i,
  input  logic [2:0][gcp_pkg::EXP_W-1:0]      e_i,
  input  logic                                bad_i,
  output logic [5:0][gcp_pkg::COV_W-1:0]      cov_o,
  output logic                                bad_o
);
  import gcp_pkg::*;

  localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

  logic [61:0]        prod_q [18];
  logic               sgn1_q [18];
  logic [30:0]        pm_q   [18];
  logic               sgn2_q [18];
  logic [56:0]        hi_q   [18];
  logic [62:0]        lo_q   [18];
  logic               sgn3_q [18];
  logic signed [60:0] trm_q  [18];
  logic [EXP_W-1:0]   e1_q   [3];
  logic [EXP_W-1:0]   e2_q   [3];
  logic signed [62:0] acc_q  [6];
  logic [5:0][COV_W-1:0] cov_q;
  logic               bad_c5;
  logic               bad_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= e_i[k];
        e2_q[k] <= e1_q[k];
      end
    end
  end

  // one term per row and upper-triangle entry
  for (genvar k = 0; k < 3; k++) begin : g_row
    for (genvar p = 0; p < 6; p++) begin : g_pair
      localparam int T = k * 6 + p;

      logic signed [31:0] ra;
      logic signed [31:0] rb;
      logic [31:0]        ma;
      logic [31:0]        mb;
      logic [61:0]        pr_sum;
      logic [63:0]        lo_rnd;
      logic [59:0]        m;

      assign ra     = $signed(rm_i[3 * k + PI[p]]);
      assign rb     = $signed(rm_i[3 * k + PJ[p]]);
      assign ma     = ra[31] ? 32'(-ra) : 32'(ra);
      assign mb     = rb[31] ? 32'(-rb) : 32'(rb);
      assign pr_sum = prod_q[T] + 62'(64'd1 << 29);
      assign lo_rnd = 64'(lo_q[T]) + (64'd1 << 29);
      assign m      = 60'({hi_q[T], 2'b00}) + 60'(lo_rnd[63:30]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[T] <= ma[30:0] * mb[30:0];
          sgn1_q[T] <= ra[31] ^ rb[31];
          pm_q[T]   <= pr_sum[60:30];
          sgn2_q[T] <= sgn1_q[T];
          hi_q[T]   <= e2_q[k][57:32] * pm_q[T];
          lo_q[T]   <= e2_q[k][31:0] * pm_q[T];
          sgn3_q[T] <= sgn2_q[T];
          trm_q[T]  <= sgn3_q[T] ? -$signed(61'(m)) : $signed(61'(m));
        end
      end
    end
  end

  gcp_dly #(
    .W (1),
    .N (COV_LAT - 1)
  ) u_bad_dly (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (bad_i),
    .q_o   (bad_c5)
  );

  // sum over rows, times four, saturate; zero when the quaternion is flagged bad
  for (genvar p = 0; p < 6; p++) begin : g_entry
    logic signed [64:0] acc4;

    assign acc4 = 65'(acc_q[p]) <<< 2;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[p] <= 63'(trm_q[p]) + 63'(trm_q[6 + p]) + 63'(trm_q[12 + p]);
        if (bad_c5) begin
          cov_q[p] <= '0;
        end else if (acc4 > 65'(COV_MAX)) begin
          cov_q[p] <= COV_MAX;
        end else if (acc4 < 65'(COV_MIN)) begin
          cov_q[p] <= COV_MIN;
        end else begin
          cov_q[p] <= acc4[COV_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad_q <= bad_c5;
    end
  end

  assign cov_o = cov_q;
  assign bad_o = bad_q;

endmodule
`default_nettype wire

// ----- design/gaussian_covariance_preprocess.sv -----
// Gaussian splat preprocessing: covariance and opacity for one Gaussian per transfer.
// Input channel in_valid_i / in_stall_o / in_data_i carries log-scales, an
// unnormalised quaternion and an opacity logit. Output channel out_valid_o /
// out_stall_i / out_data_o returns the six upper-triangle covariance entries,
// the sigmoid opacity and the zero-quaternion flag.
// Throughput is one Gaussian per cycle while the output is not stalled: every
// stage is a register stage that advances with the rest of the pipeline; the
// depth comes from the 12-term exponential series (three stages per term)
// followed by the 17-step opacity divider.
// The quaternion rotation uses nine 31-step pipelined dividers in parallel.
// Reset clears only the valid bits; no result is presented after reset until
// an input transfer has travelled the full pipeline.
// When out_stall_i is high while a result is waiting, the whole pipeline
// holds and in_stall_o rises in the same cycle; nothing is lost or repeated.
// Empty slots in the pipeline hold as well, so a stalled output does not let
// new input in until the result is taken.
`default_nettype none
module gaussian_covariance_preprocess (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gcp_pkg::gcp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gcp_pkg::gcp_out_t out_data_o
);
  import gcp_pkg::*;

  logic                  adv;
  logic [PIPE_LAT-1:0]   vld_q;

  // global advance: hold everything while a result waits on a stalled output
  assign adv        = !vld_q[PIPE_LAT-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  // exponentials: three squared scales and the negated logit
  logic signed [EXP_IN_W-1:0] arg   [4];
  logic [EXP_W-1:0]           e_val [4];

  assign arg[0] = $signed({in_data_i.log_scale_x, 1'b0});
  assign arg[1] = $signed({in_data_i.log_scale_y, 1'b0});
  assign arg[2] = $signed({in_data_i.log_scale_z, 1'b0});
  assign arg[3] = 17'sd0 - 17'(in_data_i.opacity_logit);

  for (genvar i = 0; i < 4; i++) begin : g_exp
    gcp_exp u_exp (
      .clk_i (clk_i),
      .en_i  (adv),
      .arg_i (arg[i]),
      .exp_o (e_val[i])
    );
  end

  // rotation matrix
  logic [8:0][ROT_W-1:0] rm;
  logic                  rbad;
  logic [8:0][ROT_W-1:0] rm_al;
  logic                  rbad_al;

  gcp_rot u_rot (
    .clk_i    (clk_i),
    .en_i     (adv),
    .quat_w_i (in_data_i.quat_w),
    .quat_x_i (in_data_i.quat_x),
    .quat_y_i (in_data_i.quat_y),
    .quat_z_i (in_data_i.quat_z),
    .rm_o     (rm),
    .bad_o    (rbad)
  );

  gcp_dly #(
    .W (9 * ROT_W + 1),
    .N (EXP_LAT - ROT_LAT)
  ) u_rot_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({rbad, rm}),
    .q_o   ({rbad_al, rm_al})
  );

  // covariance
  logic [2:0][EXP_W-1:0] e_pk;
  logic [5:0][COV_W-1:0] cov;
  logic                  cbad;
  logic [5:0][COV_W-1:0] cov_al;
  logic                  cbad_al;

  assign e_pk[0] = e_val[0];
  assign e_pk[1] = e_val[1];
  assign e_pk[2] = e_val[2];

  gcp_cov u_cov (
    .clk_i (clk_i),
    .en_i  (adv),
    .rm_i  (rm_al),
    .e_i   (e_pk),
    .bad_i (rbad_al),
    .cov_o (cov),
    .bad_o (cbad)
  );

  gcp_dly #(
    .W (6 * COV_W + 1),
    .N (OPA_LAT - EXP_LAT - COV_LAT)
  ) u_cov_dly (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   ({cbad, cov}),
    .q_o   ({cbad_al, cov_al})
  );

  // opacity: 2^48 / (2^32 + exp(-logit)), rounded, clipped to the all-ones maximum
  logic [43:0]       op_den_q;
  logic [48:0]       op_num_q;
  logic [43:0]       op_den_d;
  logic [OPA_QW-1:0] op_quo;
  logic [OPA_W-1:0]  opa_q;

  assign op_den_d = 44'(64'd1 << 32) + 44'(e_val[3]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_den_q <= op_den_d;
      op_num_q <= 49'(64'd1 << 48) + 49'(op_den_d[43:1]);
    end
  end

  gcp_div #(
    .NW (49),
    .DW (44),
    .QW (OPA_QW)
  ) u_opa_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (op_num_q),
    .den_i (op_den_q),
    .quo_o (op_quo)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      opa_q <= op_quo[OPA_QW-1] ? {OPA_W{1'b1}} : op_quo[OPA_W-1:0];
    end
  end

  // result transfer
  assign out_valid_o         = vld_q[PIPE_LAT-1];
  assign out_data_o.cov_xx   = cov_al[0];
  assign out_data_o.cov_xy   = cov_al[1];
  assign out_data_o.cov_xz   = cov_al[2];
  assign out_data_o.cov_yy   = cov_al[3];
  assign out_data_o.cov_yz   = cov_al[4];
  assign out_data_o.cov_zz   = cov_al[5];
  assign out_data_o.opacity  = opa_q;
  assign out_data_o.bad_quat = cbad_al;

endmodule
`default_nettype wire
